[design/json_string_escaper_defines.svh]
// Assertion macros for the JSON string escaper.
// Included by the top level; no other dependencies.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH
`ifndef SYNTHESIS
`define JSE_ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: label");
`define JSE_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define JSE_ASSERT_IMPL(label, clk, rst, cond, cons)
`define JSE_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

[design/jse_pkg.sv]
// Shared types, character constants and lookup functions for the JSON
// string escaper. No dependencies.
package jse_pkg;

  localparam int unsigned IdxW = 3;
  localparam int unsigned CntW = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CTL_LIMIT = 8'd32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       string_first;
    logic       string_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       text_end;
  } res_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h37 + {4'h0, n};
  endfunction

  // escape letter for bytes with a two-character form, zero otherwise
  function automatic logic [7:0] short_code(input logic [7:0] b);
    case (b)
      8'h22:   return 8'h22;
      8'h5C:   return 8'h5C;
      8'h08:   return 8'h62;
      8'h0C:   return 8'h66;
      8'h0A:   return 8'h6E;
      8'h0D:   return 8'h72;
      8'h09:   return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

endpackage

[design/jse_expand.sv]
// Expansion of one held item into its escaped byte sequence.
// Selects the byte at a given position and reports the sequence length; uses jse_pkg.
module jse_expand (
  input  jse_pkg::item_t              item,
  input  logic [jse_pkg::IdxW-1:0]    idx,
  output jse_pkg::res_t               res,
  output logic [jse_pkg::CntW-1:0]    cnt
);

  logic [7:0]               sc;
  logic                     is_ctl;
  logic [2:0]               body_len;
  logic [jse_pkg::IdxW-1:0] j;
  logic [7:0]               body_char;

  always_comb begin
    sc       = jse_pkg::short_code(item.in_byte);
    is_ctl   = item.in_byte < jse_pkg::CTL_LIMIT;
    if (!item.has_byte) begin
      body_len = 3'd0;
    end else if (sc != 8'h00) begin
      body_len = 3'd2;
    end else if (is_ctl) begin
      body_len = 3'd6;
    end else begin
      body_len = 3'd1;
    end
    cnt = {3'b000, item.string_first} + {1'b0, body_len} + {3'b000, item.string_last};
    j   = idx - {2'b00, item.string_first};

    if (sc != 8'h00) begin
      body_char = (j == 3'd0) ? jse_pkg::CH_BSLASH : sc;
    end else if (is_ctl) begin
      case (j)
        3'd0:    body_char = jse_pkg::CH_BSLASH;
        3'd1:    body_char = jse_pkg::CH_U;
        3'd2:    body_char = jse_pkg::CH_ZERO;
        3'd3:    body_char = jse_pkg::CH_ZERO;
        3'd4:    body_char = jse_pkg::hex_digit(item.in_byte[7:4]);
        default: body_char = jse_pkg::hex_digit(item.in_byte[3:0]);
      endcase
    end else begin
      body_char = item.in_byte;
    end

    if (item.string_first && idx == 3'd0) begin
      res.out_char = jse_pkg::CH_QUOTE;
    end else if (j < body_len) begin
      res.out_char = body_char;
    end else begin
      res.out_char = jse_pkg::CH_QUOTE;
    end
    res.run_last = ({1'b0, idx} == cnt - 4'd1);
    res.text_end = item.string_last && res.run_last;
  end

endmodule

[design/jse_out_reg.sv]
// Output register stage: holds one result word until the sink takes it.
// Uses jse_pkg.
module jse_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  output logic          load_ready,
  input  jse_pkg::res_t load_res,
  output logic          valid,
  input  logic          ready,
  output jse_pkg::res_t res
);

  assign load_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
    if (load_ready && load_valid) begin
      res <= load_res;
    end
  end

endmodule

[design/json_string_escaper.sv]
// JSON string escaper top level: item hold register, expansion, output register.
// An item gives 0 to 8 bytes, one per cycle while the sink keeps m_axis_tready high.
// The first byte of an accepted item passes the hold register and expansion into the output register.
// A new item is taken only as the held item loads its last byte, or at once if it gives no bytes.
// Reset (rst, synchronous) empties the hold and output registers.
// Depends on jse_pkg, jse_expand, jse_out_reg and json_string_escaper_defines.svh.
`include "json_string_escaper_defines.svh"

module json_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic [1:0] s_axis_tuser,  // [0] has_byte, [1] string_first
  input  logic       s_axis_tlast,  // string_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_char
  output logic [0:0] m_axis_tuser,  // [0] text_end
  output logic       m_axis_tlast   // run_last
);

  logic                       hold_valid;
  jse_pkg::item_t             hold_item;
  logic [jse_pkg::IdxW-1:0]   idx;
  jse_pkg::res_t              exp_res;
  logic [jse_pkg::CntW-1:0]   cnt;
  logic                       load_ready;
  logic                       load_valid;
  logic                       hold_step;
  logic                       hold_done;
  logic                       in_accept;
  jse_pkg::res_t              out_res;

  jse_expand u_expand (
    .item (hold_item),
    .idx  (idx),
    .res  (exp_res),
    .cnt  (cnt)
  );

  assign load_valid    = hold_valid && (cnt != 4'd0);
  assign hold_step     = hold_valid && ((cnt == 4'd0) || load_ready);
  assign hold_done     = hold_step && ((cnt == 4'd0) || exp_res.run_last);
  assign s_axis_tready = !hold_valid || hold_done;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
      idx        <= '0;
    end else if (hold_done) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (hold_step) begin
      idx <= idx + 3'd1;
    end
    if (in_accept) begin
      hold_item.in_byte      <= s_axis_tdata;
      hold_item.has_byte     <= s_axis_tuser[0];
      hold_item.string_first <= s_axis_tuser[1];
      hold_item.string_last  <= s_axis_tlast;
    end
  end

  jse_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load_res   (exp_res),
    .valid      (m_axis_tvalid),
    .ready      (m_axis_tready),
    .res        (out_res)
  );

  assign m_axis_tdata    = out_res.out_char;
  assign m_axis_tlast    = out_res.run_last;
  assign m_axis_tuser[0] = out_res.text_end;

  `JSE_ASSERT_IMPL(a_end_is_quote, clk, rst, m_axis_tvalid && m_axis_tuser[0],
                   m_axis_tlast && (m_axis_tdata == jse_pkg::CH_QUOTE))
  `JSE_ASSERT_IMPL(a_accept_busy, clk, rst, in_accept && hold_valid, hold_done)
  `JSE_ASSERT_IMPL(a_idx_range, clk, rst, hold_valid && (cnt != 4'd0), ({1'b0, idx} < cnt))
  `JSE_ASSERT_NEXT(a_hold_keeps, clk, rst, hold_valid && !hold_done,
                   hold_valid && $stable(hold_item))

endmodule
